// ===== hw/rtl/integer_list_ingest_checker_top_macros.svh =====
// Assertion macros shared by the checker of the integer list ingest block.
`ifndef INTEGER_LIST_INGEST_CHECKER_TOP_MACROS_SVH
`define INTEGER_LIST_INGEST_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ILIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ILIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ilic_pkg.sv =====
// Shared constants, codes and chain types of the integer list ingest block.
package ilic_pkg;

  localparam int MAX_ENTRIES = 512;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int HELD_W      = 10;
  localparam int VAL_W       = 32;

  typedef enum logic [2:0] {
    STAT_STORED     = 3'd0,
    STAT_NOT_NUMBER = 3'd1,
    STAT_RANGE      = 3'd2,
    STAT_DUPLICATE  = 3'd3,
    STAT_FULL       = 3'd4,
    STAT_FAILED     = 3'd5
  } status_t;

  // Search token walking down the cell chain toward cell 0.
  typedef struct packed {
    logic valid;
    logic hit;
  } tok_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             inject;
    logic [IDX_W-1:0] inj_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [VAL_W-1:0] query;
  } bcast_t;

endpackage

// ===== hw/rtl/ilic_cell.sv =====
// One list cell: holds a stored value and compares the passing search token.
module ilic_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ilic_pkg::IDX_W-1:0] idx,
  input  ilic_pkg::bcast_t           bc,
  input  ilic_pkg::tok_t             tok_in,
  output ilic_pkg::tok_t             tok_out
);
  import ilic_pkg::*;

  logic [VAL_W-1:0] stored;
  logic             tv;
  logic             th;
  logic             start;

  // search enters at the topmost live cell
  assign start = bc.inject && (bc.inj_idx == idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= 1'b0;
    end else begin
      tv <= start | tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    th <= start ? 1'b0 : tok_in.hit;
    if (bc.wr_en && (bc.wr_idx == idx)) begin
      stored <= bc.query;
    end
  end

  assign tok_out.valid = tv;
  assign tok_out.hit   = th | (stored == bc.query);

endmodule

// ===== hw/rtl/integer_list_ingest_checker_top.sv =====
// Top level of the integer list ingest block: parser, controller and cell chain.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------------
//   arg     | arg_valid | arg_stall | command, character
//   res     | res_valid | res_stall | value, status, entries_held
//
// A character or clear transaction is handled in S_IDLE. An end-of-argument
// transaction goes to S_DECIDE when no search is needed, else through S_SCAN
// first: the search token walks the cell chain one cell a cycle, from the
// newest entry down to cell 0. S_DECIDE waits for room in the output register;
// once there, characters keep flowing while the result waits on res_stall.
// Reset (rst, synchronous) clears control state only; the stored values
// need no clearing pass since only entries below the count are searched.
module integer_list_ingest_checker_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           arg_valid,
  output logic                           arg_stall,
  input  logic [1:0]                     command,
  input  logic [7:0]                     character,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic signed [ilic_pkg::VAL_W-1:0] value,
  output logic [2:0]                     status,
  output logic [ilic_pkg::HELD_W-1:0]    entries_held
);
  import ilic_pkg::*;

  localparam logic [1:0] CMD_CHAR  = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // progress through the current argument
  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;

  // per-argument parse state
  logic [VAL_W-1:0]  magnitude;
  logic              neg;
  phase_t            phase;
  logic              bad;

  // list state
  logic              failed;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  // pending end-of-argument transaction
  logic [VAL_W-1:0]  query;
  status_t           pend;
  logic              dup;

  // output register
  logic [VAL_W-1:0]  res_value;
  status_t           res_status;
  logic [HELD_W-1:0] res_held;

  logic              arg_accept;
  logic              is_end;
  logic              is_sign;
  logic              is_digit;
  logic [VAL_W+3:0]  mag_wide;
  logic [VAL_W-1:0]  mag_sat;
  logic              range_bad;
  status_t           end_status;
  logic              need_scan;
  logic              can_emit;
  logic              decide_fire;
  logic              full;
  status_t           dec_status;
  logic              store_en;

  bcast_t            bc;
  tok_t              tok [MAX_ENTRIES+1];

  assign arg_stall  = !(state == S_IDLE);
  assign arg_accept = arg_valid && !arg_stall;
  assign is_end     = arg_accept && (command == CMD_END);

  // character classes
  assign is_sign  = (character == 8'h2D) || (character == 8'h2B);
  assign is_digit = (character >= 8'h30) && (character <= 8'h39);

  // magnitude * 10 + digit, saturating at all ones
  assign mag_wide = ({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1)
                  + (VAL_W+4)'(character[3:0]);
  assign mag_sat  = (|mag_wide[VAL_W+3:VAL_W]) ? '1 : mag_wide[VAL_W-1:0];

  assign range_bad = magnitude > (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);

  always_comb begin
    priority if (failed) begin
      end_status = STAT_FAILED;
    end else if (bad || (phase != PH_DIGIT)) begin
      end_status = STAT_NOT_NUMBER;
    end else if (range_bad) begin
      end_status = STAT_RANGE;
    end else begin
      end_status = STAT_STORED;
    end
  end

  assign need_scan = (end_status == STAT_STORED) && (count != '0);

  // verdict once the search is over
  assign can_emit    = !res_valid || !res_stall;
  assign decide_fire = (state == S_DECIDE) && can_emit;
  assign full        = (count == CNT_W'(MAX_ENTRIES));

  always_comb begin
    store_en   = 1'b0;
    dec_status = pend;
    if (pend == STAT_STORED) begin
      priority if (dup) begin
        dec_status = STAT_DUPLICATE;
      end else if (full) begin
        dec_status = STAT_FULL;
      end else begin
        store_en = 1'b1;
      end
    end
    priority if (store_en) begin
      count_next = count + CNT_W'(1);
    end else if (dec_status == STAT_FAILED) begin
      count_next = count;
    end else begin
      count_next = '0;
    end
  end

  // broadcast into the chain
  assign bc.inject  = is_end && need_scan;
  assign bc.inj_idx = IDX_W'(count - CNT_W'(1));
  assign bc.wr_en   = decide_fire && store_en;
  assign bc.wr_idx  = IDX_W'(count);
  assign bc.query   = query;

  // cell chain; the token enters high and leaves at cell 0
  assign tok[MAX_ENTRIES] = '0;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    ilic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(k)),
      .bc      (bc),
      .tok_in  (tok[k+1]),
      .tok_out (tok[k])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (is_end) begin
          state_next = need_scan ? S_SCAN : S_DECIDE;
        end
      end
      S_SCAN: begin
        if (tok[0].valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (can_emit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      magnitude <= '0;
      neg       <= 1'b0;
      phase     <= PH_NONE;
      bad       <= 1'b0;
      failed    <= 1'b0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (arg_accept) begin
        unique case (command)
          CMD_CHAR: begin
            priority if ((phase == PH_NONE) && is_sign) begin
              neg   <= (character == 8'h2D);
              phase <= PH_SIGN;
            end else if (is_digit) begin
              magnitude <= mag_sat;
              phase     <= PH_DIGIT;
            end else begin
              bad   <= 1'b1;
              phase <= PH_DIGIT;
            end
          end
          CMD_END: begin
            magnitude <= '0;
            neg       <= 1'b0;
            phase     <= PH_NONE;
            bad       <= 1'b0;
          end
          CMD_CLEAR: begin
            magnitude <= '0;
            neg       <= 1'b0;
            phase     <= PH_NONE;
            bad       <= 1'b0;
            failed    <= 1'b0;
            count     <= '0;
          end
          default: begin
          end
        endcase
      end
      if (decide_fire) begin
        count     <= count_next;
        if ((dec_status != STAT_STORED) && (dec_status != STAT_FAILED)) begin
          failed <= 1'b1;
        end
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (is_end) begin
      query <= neg ? (32'd0 - magnitude) : magnitude;
      pend  <= end_status;
      dup   <= 1'b0;
    end else if ((state == S_SCAN) && tok[0].valid) begin
      dup <= tok[0].hit;
    end
    if (decide_fire) begin
      res_value  <= store_en ? query : '0;
      res_status <= dec_status;
      res_held   <= HELD_W'(count_next);
    end
  end

  assign value        = res_value;
  assign status       = res_status;
  assign entries_held = res_held;

endmodule

// ===== hw/rtl/ilic_checker.sv =====
// Port-level assertions for the integer list ingest block, bound to its top.
`include "integer_list_ingest_checker_top_macros.svh"

module ilic_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              res_valid,
  input logic                              res_stall,
  input logic signed [ilic_pkg::VAL_W-1:0] value,
  input logic [2:0]                        status,
  input logic [ilic_pkg::HELD_W-1:0]       entries_held
);
  import ilic_pkg::*;

  // anything but a stored result carries a zero value
  `ILIC_ASSERT_NOW(a_value_zero, res_valid && (status != STAT_STORED), value == '0, "nonzero value on unstored result")

  // every error or failed result leaves the list empty
  `ILIC_ASSERT_NOW(a_list_empty, res_valid && (status != STAT_STORED), entries_held == '0, "list not empty after error")

  // a stalled result holds
  `ILIC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(value) && $stable(status) && $stable(entries_held), "result changed under stall")

endmodule

bind integer_list_ingest_checker_top ilic_checker u_ilic_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .value        (value),
  .status       (status),
  .entries_held (entries_held)
);

// ===== tb/integer_list_ingest_checker_tb.sv =====
// Self-checking testbench for the integer list ingest block: directed table, random args, list fill.
`timescale 1ns / 1ps

module testbench;
  import ilic_pkg::*;

  localparam int     HALF_PERIOD  = 6;
  localparam int     RESET_CYCLES = 12;
  localparam int     RANDOM_ITEMS = 150;
  localparam int     HOLD_CYCLES  = 1500;
  localparam int     MAX_REPORTS  = 10;
  // Leave room for one full-list scan.
  localparam int     DRAIN_CYCLES = 600;
  // Worst case: ~2200 transactions, each taken as an end scanning a full list
  // with the longest random gap and stall, plus the hold-off; CYCLE_LIMIT lies
  // above that sum.
  localparam longint CYCLE_LIMIT  = 6_000_000;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    CMD_CHAR    = 2'd0,
    CMD_END     = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_IGNORED = 2'd3
  } cmd_t;

  // How far the argument in progress has come.
  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_SIGN  = 2'd1,
    PH_BODY  = 2'd2
  } arg_phase_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    status_t                 status;
    logic [HELD_W-1:0]       held;
  } arg_outcome_t;

  typedef struct packed {
    cmd_t         cmd;
    logic [7:0]   ch;
    logic         fixed;    // outcome typed in below rather than computed
    arg_outcome_t outcome;
  } plan_row_t;

  localparam arg_outcome_t NO_OUTCOME = '{32'sd0, STAT_STORED, 10'd0};

  // Magnitudes around the signed 32-bit limits and the saturation point.
  localparam longint unsigned BOUNDARY [6] = '{
    64'd2147483647, 64'd2147483648, 64'd2147483649,
    64'd4294967295, 64'd4294967296, 64'd0
  };

  // Directed opening: error paths, sticky failure, clear, signs and byte extremes.
  localparam int DIRECTED_LEN = 26;
  localparam plan_row_t DIRECTED [DIRECTED_LEN] = '{
    '{CMD_END,     8'h00,    1'b1, '{32'sd0, STAT_NOT_NUMBER, 10'd0}},  // empty, out of reset
    '{CMD_END,     8'h00,    1'b1, '{32'sd0, STAT_FAILED,     10'd0}},  // failure is sticky
    '{CMD_IGNORED, 8'hFF,    1'b0, NO_OUTCOME},
    '{CMD_CLEAR,   8'h00,    1'b0, NO_OUTCOME},
    '{CMD_CHAR,    CH_MINUS, 1'b0, NO_OUTCOME},
    '{CMD_CHAR,    CH_ZERO,  1'b0, NO_OUTCOME},
    '{CMD_END,     8'h00,    1'b1, '{32'sd0, STAT_STORED,     10'd1}},  // "-0" stores zero
    '{CMD_CHAR,    CH_NINE,  1'b0, NO_OUTCOME},
    '{CMD_END,     8'h55,    1'b1, '{32'sd9, STAT_STORED,     10'd2}},
    '{CMD_CHAR,    CH_PLUS,  1'b0, NO_OUTCOME},
    '{CMD_CHAR,    CH_NINE,  1'b0, NO_OUTCOME},
    '{CMD_END,     8'hAA,    1'b1, '{32'sd0, STAT_DUPLICATE,  10'd0}},  // "+9" repeats 9
    '{CMD_CLEAR,   8'hFF,    1'b0, NO_OUTCOME},
    '{CMD_CHAR,    CH_PLUS,  1'b0, NO_OUTCOME},
    '{CMD_END,     8'h00,    1'b1, '{32'sd0, STAT_NOT_NUMBER, 10'd0}},  // sign alone
    '{CMD_CLEAR,   8'h00,    1'b0, NO_OUTCOME},
    '{CMD_CHAR,    CH_NINE,  1'b0, NO_OUTCOME},
    '{CMD_CHAR,    CH_MINUS, 1'b0, NO_OUTCOME},
    '{CMD_END,     8'h00,    1'b1, '{32'sd0, STAT_NOT_NUMBER, 10'd0}},  // sign after a digit
    '{CMD_CLEAR,   8'h00,    1'b0, NO_OUTCOME},
    '{CMD_CHAR,    8'h00,    1'b0, NO_OUTCOME},
    '{CMD_END,     8'h00,    1'b1, '{32'sd0, STAT_NOT_NUMBER, 10'd0}},  // NUL byte
    '{CMD_CLEAR,   8'h00,    1'b0, NO_OUTCOME},
    '{CMD_CHAR,    8'hFF,    1'b0, NO_OUTCOME},
    '{CMD_END,     8'h00,    1'b1, '{32'sd0, STAT_NOT_NUMBER, 10'd0}},  // top byte value
    '{CMD_CLEAR,   8'h00,    1'b0, NO_OUTCOME}
  };

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    arg_valid = 1'b0;
  logic                    arg_stall;
  logic [1:0]              command   = CMD_CHAR;
  logic [7:0]              character = 8'h00;
  logic                    res_valid;
  logic                    res_stall = 1'b0;
  logic signed [VAL_W-1:0] value;
  logic [2:0]              status;
  logic [HELD_W-1:0]       entries_held;

  integer_list_ingest_checker_top dut (
    .clk          (clk),
    .rst          (rst),
    .arg_valid    (arg_valid),
    .arg_stall    (arg_stall),
    .command      (command),
    .character    (character),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .value        (value),
    .status       (status),
    .entries_held (entries_held)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the block's state, kept in step with accepted transactions.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] list_vals [MAX_ENTRIES];
  int unsigned      list_len    = 0;
  int unsigned      peak_len    = 0;
  logic             list_failed = 1'b0;
  logic [31:0]      acc_mag     = '0;
  logic             acc_neg     = 1'b0;
  arg_phase_t       acc_phase   = PH_EMPTY;
  logic             acc_bad     = 1'b0;

  arg_outcome_t     outcomes_due [$];   // results owed by the block, oldest first
  logic [7:0]       arg_bytes [$];      // characters of the argument being built

  int               useful_items = 0;   // accepted transactions the block acts on
  int               results_seen = 0;
  int               mismatches   = 0;
  int               status_seen [6];
  longint           cycles       = 0;
  logic             send_burst   = 1'b0;
  logic             hold_off     = 1'b0;

  // Applies one transaction to the shadow state; returns 1 when it yields a result.
  function automatic logic parse_and_store(input cmd_t cmd, input logic [7:0] ch,
                                           output arg_outcome_t res);
    logic [35:0] prod;
    logic [31:0] v;
    logic        dup;
    logic        has;
    status_t     st;
    int unsigned i;
    res = NO_OUTCOME;
    has = 1'b0;
    case (cmd)
      CMD_CHAR: begin
        if (acc_phase == PH_EMPTY && (ch == CH_MINUS || ch == CH_PLUS)) begin
          acc_neg   = (ch == CH_MINUS);
          acc_phase = PH_SIGN;
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
          prod      = 36'(acc_mag) * 36'd10 + 36'(ch - CH_ZERO);
          acc_mag   = (prod > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
          acc_phase = PH_BODY;
        end else begin
          acc_bad   = 1'b1;
          acc_phase = PH_BODY;
        end
      end
      CMD_END: begin
        has = 1'b1;
        v   = acc_neg ? (32'd0 - acc_mag) : acc_mag;
        dup = 1'b0;
        for (i = 0; i < list_len; i++)
          if (list_vals[i] == v) dup = 1'b1;
        // Error priority: failed, not a number, range, duplicate, full.
        st = STAT_STORED;
        if (list_failed) st = STAT_FAILED;
        else if (acc_bad || acc_phase != PH_BODY) st = STAT_NOT_NUMBER;
        else if (acc_mag > (acc_neg ? 32'h8000_0000 : 32'h7FFF_FFFF)) st = STAT_RANGE;
        else if (dup) st = STAT_DUPLICATE;
        else if (list_len >= MAX_ENTRIES) st = STAT_FULL;
        if (st == STAT_STORED) begin
          list_vals[list_len] = v;
          list_len++;
          if (list_len > peak_len) peak_len = list_len;
          res.value = v;
        end else if (st != STAT_FAILED) begin
          list_len    = 0;
          list_failed = 1'b1;
        end
        res.status = st;
        res.held   = HELD_W'(list_len);
        acc_mag = '0; acc_neg = 1'b0; acc_phase = PH_EMPTY; acc_bad = 1'b0;
      end
      CMD_CLEAR: begin
        list_len    = 0;
        list_failed = 1'b0;
        acc_mag = '0; acc_neg = 1'b0; acc_phase = PH_EMPTY; acc_bad = 1'b0;
      end
      default: ;  // command 3 leaves everything alone
    endcase
    return has;
  endfunction

  // ---------------------------------------------------------------------------
  // Argument side: one transaction per call, random gap first, then wait for
  // the handshake. Valid is only lowered when a gap is actually taken, so a
  // back-to-back transaction never sees valid dropped and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_txn(input cmd_t cmd, input logic [7:0] ch,
                          input logic fixed, input arg_outcome_t fixed_outcome);
    int           gap;
    logic         has;
    arg_outcome_t res;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      arg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    arg_valid <= 1'b1;
    command   <= cmd;
    character <= ch;
    do @(posedge clk); while (arg_stall);
    if (cmd != CMD_IGNORED) useful_items++;
    has = parse_and_store(cmd, ch, res);
    if (has) outcomes_due.push_back(fixed ? fixed_outcome : res);
    // occasionally flip into or out of a stretch with no idling
    if ($urandom_range(0, 99) == 0) send_burst = ~send_burst;
  endtask

  task automatic push_decimal(input longint unsigned mag);
    logic [7:0] digits [$];
    do begin
      digits.push_front(CH_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    foreach (digits[i]) arg_bytes.push_back(digits[i]);
  endtask

  // Sends the built argument and its end command. With noise on, stray
  // command-3 transactions and an odd mid-argument clear get mixed in.
  task automatic send_arg(input logic noisy);
    foreach (arg_bytes[i]) begin
      if (noisy && $urandom_range(0, 49) == 0)
        send_txn(CMD_IGNORED, 8'($urandom_range(0, 255)), 1'b0, NO_OUTCOME);
      if (noisy && $urandom_range(0, 199) == 0)
        send_txn(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'b0, NO_OUTCOME);
      send_txn(CMD_CHAR, arg_bytes[i], 1'b0, NO_OUTCOME);
    end
    send_txn(CMD_END, 8'($urandom_range(0, 255)), 1'b0, NO_OUTCOME);
  endtask

  // Mostly well-formed arguments with random content; the rest malformed.
  task automatic build_random_arg();
    int         s;
    int         k;
    logic [7:0] sgn;
    arg_bytes.delete();
    sgn = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
    if ($urandom_range(0, 99) < 85) begin
      s = $urandom_range(0, 3);
      if (s < 2) arg_bytes.push_back(CH_MINUS);
      else if (s == 2) arg_bytes.push_back(CH_PLUS);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) arg_bytes.push_back(CH_ZERO);
      k = $urandom_range(0, 99);
      if (k < 40) push_decimal($urandom_range(0, 40));          // duplicates likely
      else if (k < 60) push_decimal($urandom);
      else if (k < 72) push_decimal(BOUNDARY[$urandom_range(0, 5)]);
      else if (k < 80)                                           // long digit runs, mostly saturating
        repeat ($urandom_range(11, 25)) arg_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      else push_decimal($urandom_range(0, 999999));
    end else begin
      case ($urandom_range(0, 4))
        0: ;                                   // empty argument
        1: arg_bytes.push_back(sgn);           // sign alone
        2: begin                               // sign not in first place
          push_decimal($urandom_range(0, 999));
          arg_bytes.push_back(sgn);
          push_decimal($urandom_range(0, 999));
        end
        3: repeat ($urandom_range(1, 4)) arg_bytes.push_back(8'($urandom_range(0, 255)));
        default: begin                         // one stray byte somewhere in a number
          push_decimal($urandom_range(0, 99999));
          arg_bytes.insert($urandom_range(0, arg_bytes.size()), 8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall after each result, plus the long hold-off.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int           wait_left;
    logic         burst;
    arg_outcome_t want;
    wait_left = 0;
    burst     = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        results_seen++;
        if (status < 6) status_seen[status]++;
        if (outcomes_due.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result with none outstanding: value %0d status %0d held %0d",
                     $realtime, value, status, entries_held);
          mismatches++;
        end else begin
          want = outcomes_due.pop_front();
          if (value !== want.value || status !== want.status || entries_held !== want.held)
          begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: result %0d exp value %0d status %0d held %0d, got %0d %0d %0d",
                       $realtime, results_seen, want.value, want.status, want.held,
                       value, status, entries_held);
            mismatches++;
          end
        end
        wait_left = burst ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 99) == 0) burst = ~burst;
      end
      res_stall <= hold_off || (wait_left > 0);
      if (wait_left > 0) wait_left--;
    end
  end

  // Once the random part is under way, block results for a long stretch so the
  // output register fills and the next end-of-argument backs up the input.
  initial begin : result_hold_off
    while (useful_items < DIRECTED_LEN + 80) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, outcomes_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, random arguments, then fill the list.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    int start;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_LEN; i++)
      send_txn(DIRECTED[i].cmd, DIRECTED[i].ch, DIRECTED[i].fixed, DIRECTED[i].outcome);

    // After a failure the list is usually cleared at once; sometimes a few
    // more arguments run into the sticky failure first.
    start = useful_items;
    while (useful_items - start < RANDOM_ITEMS) begin
      if (list_failed ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 49) == 0))
        send_txn(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'b0, NO_OUTCOME);
      build_random_arg();
      send_arg(1'b1);
    end

    // Fill the list with 0 up to MAX_ENTRIES - 1 in the shortest form; the
    // last value then finds it full.
    send_txn(CMD_CLEAR, 8'h00, 1'b0, NO_OUTCOME);
    for (i = 0; i <= MAX_ENTRIES; i++) begin
      arg_bytes.delete();
      push_decimal(i);
      send_arg(1'b0);
    end
    send_txn(CMD_END, 8'h00, 1'b0, NO_OUTCOME);
    arg_valid <= 1'b0;

    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results; list reached %0d of %0d entries",
             useful_items, results_seen, peak_len, MAX_ENTRIES);
    $display("Statuses: stored %0d, not a number %0d, range %0d, dup %0d, full %0d, failed %0d",
             status_seen[STAT_STORED], status_seen[STAT_NOT_NUMBER], status_seen[STAT_RANGE],
             status_seen[STAT_DUPLICATE], status_seen[STAT_FULL], status_seen[STAT_FAILED]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
